FILE: sv/rwlt_pkg.sv
// ----------------------------------------------------------------------------
// rwlt_pkg: shared types and codes for the reader/writer lock table
// Request and result codes, field widths, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rwlt_pkg;

  // Field widths
  localparam int REQ_W    = 3;
  localparam int KEY_W    = 16;
  localparam int CID_W    = 4;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 2;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_ACQ_READ    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ACQ_WRITE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RELEASE_ALL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY       = 3'd4;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Mode held by the client
  localparam logic [HELD_W-1:0] HELD_NONE  = 2'd0;
  localparam logic [HELD_W-1:0] HELD_READ  = 2'd1;
  localparam logic [HELD_W-1:0] HELD_WRITE = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the request word and restart the scan
    logic scan;   // walk the table one entry a cycle
    logic apply;  // commit the decision and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // last entry has been compared
    logic out_free;   // result register can take a new word
  } stat_t;

endpackage

FILE: sv/rwlt_datapath.sv
// ----------------------------------------------------------------------------
// rwlt_datapath: lock table storage, scan and decision logic
// Holds the entry memory and valid bits, walks the table one entry per cycle
// to find the record and the first free slot, drops a client from every
// entry on release all, and commits the decision into the table.
// ----------------------------------------------------------------------------
module rwlt_datapath #(
  parameter int TABLE_ENTRIES = 16,
  parameter int CLIENT_COUNT  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rwlt_pkg::cmd_t               cmd,
  output rwlt_pkg::stat_t              stat,
  input  logic [rwlt_pkg::REQ_W-1:0]   in_req_type,
  input  logic [rwlt_pkg::KEY_W-1:0]   in_record_key,
  input  logic [rwlt_pkg::CID_W-1:0]   in_client_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rwlt_pkg::STATUS_W-1:0] out_status,
  output logic [rwlt_pkg::HELD_W-1:0]  out_held_type,
  output logic                         out_holds_lock
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef logic [CLIENT_COUNT-1:0] mask_t;

  typedef struct packed {
    logic [rwlt_pkg::KEY_W-1:0] key;
    logic                       is_write;
    mask_t                      mask;
  } entry_t;

  // Request word
  logic [rwlt_pkg::REQ_W-1:0] req_type;
  logic [rwlt_pkg::KEY_W-1:0] req_key;
  logic [rwlt_pkg::CID_W-1:0] req_cid;

  // Table storage
  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   rd_data;
  logic [TABLE_ENTRIES-1:0] valid_q;

  // Scan control
  logic             issuing;
  logic [IDX_W-1:0] scan_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;

  // Scan findings
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_data;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // Decision signals
  logic       client_ok;
  mask_t      bit_sel;
  logic       issue;
  logic       eval;
  logic       ra_drop;
  mask_t      ra_mask;
  logic       ap_we;
  logic [IDX_W-1:0] ap_idx;
  entry_t     ap_entry;
  logic       ap_set_valid;
  logic       ap_clr_valid;
  logic [rwlt_pkg::STATUS_W-1:0] res_status;
  logic [rwlt_pkg::HELD_W-1:0]   res_held;
  logic       res_holds;
  logic       holds_bit;
  logic       mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t     mem_wdata;

  // Client bit, zero for a client outside the mask
  assign client_ok = 32'(req_cid) < 32'(CLIENT_COUNT);
  assign bit_sel   = client_ok ? (mask_t'(1) << req_cid) : '0;

  assign issue = cmd.scan && issuing;
  assign eval  = cmd.scan && pend;

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type <= in_req_type;
      req_key  <= in_record_key;
      req_cid  <= in_client_id;
    end
  end

  // Advance the scan address and the compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      pend     <= 1'b0;
      scan_idx <= '0;
      pend_idx <= '0;
    end else if (cmd.load) begin
      issuing  <= 1'b1;
      pend     <= 1'b0;
      scan_idx <= '0;
    end else if (issue) begin
      pend     <= 1'b1;
      pend_idx <= scan_idx;
      if (scan_idx == LAST_IDX) begin
        issuing <= 1'b0;
      end else begin
        scan_idx <= scan_idx + 1'b1;
      end
    end else begin
      pend <= 1'b0;
    end
  end

  // Track the first matching entry and the first free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (eval) begin
      if (!hit_found && valid_q[pend_idx] && rd_data.key == req_key) begin
        hit_found <= 1'b1;
      end
      if (!free_found && !valid_q[pend_idx]) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval && !hit_found && valid_q[pend_idx] && rd_data.key == req_key) begin
      hit_idx  <= pend_idx;
      hit_data <= rd_data;
    end
    if (eval && !free_found && !valid_q[pend_idx]) begin
      free_idx <= pend_idx;
    end
  end

  // Release all: drop the client from each valid entry as it passes
  assign ra_drop = eval && req_type == rwlt_pkg::REQ_RELEASE_ALL && client_ok
                   && valid_q[pend_idx];
  assign ra_mask = rd_data.mask & ~bit_sel;

  // Decide the request from the scan findings
  always_comb begin
    ap_we        = 1'b0;
    ap_idx       = hit_idx;
    ap_entry     = hit_data;
    ap_set_valid = 1'b0;
    ap_clr_valid = 1'b0;
    res_status   = rwlt_pkg::ST_OK;
    res_held     = rwlt_pkg::HELD_NONE;
    res_holds    = 1'b0;
    holds_bit    = (hit_data.mask & bit_sel) != '0;
    case (req_type)
      rwlt_pkg::REQ_ACQ_READ, rwlt_pkg::REQ_ACQ_WRITE: begin
        if (!client_ok) begin
          res_status = rwlt_pkg::ST_CONFLICT;
        end else if (!hit_found) begin
          if (!free_found) begin
            res_status = rwlt_pkg::ST_FULL;
          end else begin
            ap_we             = 1'b1;
            ap_idx            = free_idx;
            ap_set_valid      = 1'b1;
            ap_entry.key      = req_key;
            ap_entry.is_write = req_type == rwlt_pkg::REQ_ACQ_WRITE;
            ap_entry.mask     = bit_sel;
            res_holds         = 1'b1;
          end
        end else if (req_type == rwlt_pkg::REQ_ACQ_READ) begin
          if (!hit_data.is_write || holds_bit) begin
            ap_we             = 1'b1;
            ap_entry.is_write = 1'b0;
            ap_entry.mask     = hit_data.mask | bit_sel;
            res_holds         = 1'b1;
          end else begin
            res_status = rwlt_pkg::ST_CONFLICT;
          end
        end else begin
          if (hit_data.is_write && holds_bit) begin
            ap_we         = 1'b1;
            ap_entry.mask = bit_sel;
            res_holds     = 1'b1;
          end else begin
            res_status = rwlt_pkg::ST_CONFLICT;
            res_holds  = holds_bit;
          end
        end
      end
      rwlt_pkg::REQ_RELEASE: begin
        if (hit_found && client_ok) begin
          ap_we         = 1'b1;
          ap_entry.mask = hit_data.mask & ~bit_sel;
          ap_clr_valid  = (hit_data.mask & ~bit_sel) == '0;
        end
      end
      rwlt_pkg::REQ_QUERY: begin
        if (hit_found && holds_bit) begin
          res_held  = hit_data.is_write ? rwlt_pkg::HELD_WRITE : rwlt_pkg::HELD_READ;
          res_holds = 1'b1;
        end
      end
      default: begin
        // release all finished during the scan; unknown kinds change nothing
      end
    endcase
  end

  // Select the table write: scan-time drop or final commit
  always_comb begin
    if (ra_drop) begin
      mem_we    = 1'b1;
      mem_waddr = pend_idx;
      mem_wdata = '{key: rd_data.key, is_write: rd_data.is_write, mask: ra_mask};
    end else begin
      mem_we    = cmd.apply && ap_we;
      mem_waddr = ap_idx;
      mem_wdata = ap_entry;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[scan_idx];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (ra_drop) begin
      if (ra_mask == '0) begin
        valid_q[pend_idx] <= 1'b0;
      end
    end else if (cmd.apply) begin
      if (ap_set_valid) begin
        valid_q[ap_idx] <= 1'b1;
      end else if (ap_clr_valid) begin
        valid_q[ap_idx] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_status     <= res_status;
      out_held_type  <= res_held;
      out_holds_lock <= res_holds;
    end
  end

  assign stat.scan_done = eval && pend_idx == LAST_IDX;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

FILE: sv/rwlt_ctrl.sv
// ----------------------------------------------------------------------------
// rwlt_ctrl: request sequencer for the lock table
// Accepts one request, runs the table scan, then commits the decision once
// the result register is free.
// ----------------------------------------------------------------------------
module rwlt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rwlt_pkg::stat_t stat,
  output rwlt_pkg::cmd_t  cmd
);

  rwlt_pkg::state_t state;
  rwlt_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwlt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rwlt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = rwlt_pkg::S_SCAN;
        end
      end
      rwlt_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          state_next = rwlt_pkg::S_APPLY;
        end
      end
      rwlt_pkg::S_APPLY: begin
        if (stat.out_free) begin
          state_next = rwlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rwlt_pkg::S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      rwlt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rwlt_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      rwlt_pkg::S_APPLY: begin
        cmd.apply = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/reader_writer_lock_table.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_table: record lock table with read and write modes
// Grants, refuses and releases per-client locks on 16-bit record numbers.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: record_key, client_id
//  m_*      out  m_tvalid/m_tready  tdata: status, held_type, holds_lock
//
//  After a request is accepted, the table is walked one entry per cycle through
//  the single read port of the entry memory, the last entry is then compared,
//  and the decision is committed into the table and the result register. A
//  new request is taken only once the previous one has been committed.
//  Reset clears all valid bits at once; no clearing pass is needed.
//  A stalled result word holds in the output register; the next request is
//  taken meanwhile and its commit waits until that register is free.
// ----------------------------------------------------------------------------
module reader_writer_lock_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int CLIENT_COUNT  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] record_key, [19:16] client_id, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [1:0] status, [3:2] held_type, [4] holds_lock
);

  rwlt_pkg::cmd_t  cmd;
  rwlt_pkg::stat_t stat;

  logic [rwlt_pkg::STATUS_W-1:0] status;
  logic [rwlt_pkg::HELD_W-1:0]   held_type;
  logic                          holds_lock;

  rwlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rwlt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CLIENT_COUNT  (CLIENT_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (s_tuser),
    .in_record_key  (s_tdata[15:0]),
    .in_client_id   (s_tdata[19:16]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_status     (status),
    .out_held_type  (held_type),
    .out_holds_lock (holds_lock)
  );

  // Pack the result word
  assign m_tdata = {3'b000, holds_lock, held_type, status};

endmodule
